// ===== rtl/bdlr_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlr_pkg
// Shared types, code points and decode functions for the box-drawing raster.
// ----------------------------------------------------------------------------
package bdlr_pkg;

    localparam int CODE_W      = 21;
    localparam int COLS_REG_W  = 9;
    localparam int ROWS_W      = 12;
    localparam int ROW_CNT_W   = ROWS_W + 1;
    localparam int DIR_W       = 4;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 4'd1;

    localparam logic [COLS_REG_W-1:0] COLS_RESET = 9'd80;
    localparam logic [ROWS_W-1:0]     ROWS_RESET = 12'd24;

    localparam logic [DIR_W-1:0] DIR_UP    = 4'h1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 4'h2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 4'h4;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 4'h8;
    localparam logic [DIR_W-1:0] DIR_UD    = DIR_UP | DIR_DOWN;
    localparam logic [DIR_W-1:0] DIR_LR    = DIR_LEFT | DIR_RIGHT;
    localparam logic [DIR_W-1:0] DIR_DR    = DIR_DOWN | DIR_RIGHT;
    localparam logic [DIR_W-1:0] DIR_DL    = DIR_DOWN | DIR_LEFT;
    localparam logic [DIR_W-1:0] DIR_UR    = DIR_UP | DIR_RIGHT;
    localparam logic [DIR_W-1:0] DIR_UL    = DIR_UP | DIR_LEFT;
    localparam logic [DIR_W-1:0] DIR_UDR   = DIR_UD | DIR_RIGHT;
    localparam logic [DIR_W-1:0] DIR_UDL   = DIR_UD | DIR_LEFT;
    localparam logic [DIR_W-1:0] DIR_LRD   = DIR_LR | DIR_DOWN;
    localparam logic [DIR_W-1:0] DIR_LRU   = DIR_LR | DIR_UP;
    localparam logic [DIR_W-1:0] DIR_ALL   = DIR_UD | DIR_LR;

    localparam logic [CODE_W-1:0] CP_PLUS       = 21'h0002B;
    localparam logic [CODE_W-1:0] CP_HYPHEN     = 21'h0002D;
    localparam logic [CODE_W-1:0] CP_SLASH      = 21'h0002F;
    localparam logic [CODE_W-1:0] CP_BACKSLASH  = 21'h0005C;
    localparam logic [CODE_W-1:0] CP_UNDERSCORE = 21'h0005F;
    localparam logic [CODE_W-1:0] CP_PIPE       = 21'h0007C;
    localparam logic [CODE_W-1:0] CP_BOX_H      = 21'h02500;
    localparam logic [CODE_W-1:0] CP_BOX_V      = 21'h02502;
    localparam logic [CODE_W-1:0] CP_BOX_DR     = 21'h0250C;
    localparam logic [CODE_W-1:0] CP_BOX_DL     = 21'h02510;
    localparam logic [CODE_W-1:0] CP_BOX_UR     = 21'h02514;
    localparam logic [CODE_W-1:0] CP_BOX_UL     = 21'h02518;
    localparam logic [CODE_W-1:0] CP_BOX_VR     = 21'h0251C;
    localparam logic [CODE_W-1:0] CP_BOX_VL     = 21'h02524;
    localparam logic [CODE_W-1:0] CP_BOX_HD     = 21'h0252C;
    localparam logic [CODE_W-1:0] CP_BOX_HU     = 21'h02534;
    localparam logic [CODE_W-1:0] CP_BOX_VH     = 21'h0253C;

    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        logic              is_pad;
    } cell_t;

    typedef struct packed {
        logic [CODE_W-1:0] out_code_point;
        logic              frame_last;
    } glyph_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_t;

    // nb: directions whose in-grid neighbor supports back toward the cell
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [DIR_W-1:0]  nb;
        logic              last;
    } qentry_t;

    function automatic logic [DIR_W-1:0] support_of(input logic [CODE_W-1:0] cp);
        logic [DIR_W-1:0] s;
        unique case (cp) inside
            CP_PIPE, CP_BOX_V:                         s = DIR_UD;
            CP_HYPHEN, CP_UNDERSCORE, CP_BOX_H:        s = DIR_LR;
            CP_SLASH, CP_BACKSLASH, CP_PLUS, CP_BOX_VH: s = DIR_ALL;
            CP_BOX_DR:                                 s = DIR_DR;
            CP_BOX_DL:                                 s = DIR_DL;
            CP_BOX_UR:                                 s = DIR_UR;
            CP_BOX_UL:                                 s = DIR_UL;
            CP_BOX_VR:                                 s = DIR_UDR;
            CP_BOX_VL:                                 s = DIR_UDL;
            CP_BOX_HD:                                 s = DIR_LRD;
            CP_BOX_HU:                                 s = DIR_LRU;
            default:                                   s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [CODE_W-1:0] glyph_of(input logic [DIR_W-1:0] links,
                                                   input logic [CODE_W-1:0] fallback);
        logic [CODE_W-1:0] g;
        unique case (links) inside
            DIR_UP, DIR_DOWN, DIR_UD:    g = CP_BOX_V;
            DIR_LEFT, DIR_RIGHT, DIR_LR: g = CP_BOX_H;
            DIR_DR:                      g = CP_BOX_DR;
            DIR_DL:                      g = CP_BOX_DL;
            DIR_UR:                      g = CP_BOX_UR;
            DIR_UL:                      g = CP_BOX_UL;
            DIR_UDR:                     g = CP_BOX_VR;
            DIR_UDL:                     g = CP_BOX_VL;
            DIR_LRD:                     g = CP_BOX_HD;
            DIR_LRU:                     g = CP_BOX_HU;
            DIR_ALL:                     g = CP_BOX_VH;
            default:                     g = fallback;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/bdlr_stream_if.sv =====
// ----------------------------------------------------------------------------
// bdlr_stream_if
// Valid/ready channel; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bdlr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bdlr_ram.sv =====
// ----------------------------------------------------------------------------
// bdlr_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bdlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

// ===== rtl/bdlr_geom.sv =====
// ----------------------------------------------------------------------------
// bdlr_geom
// Config registers, clamped geometry, frame period, and a bit-serial divider
// that re-derives row/column of the held position after reset and each config write.
// ----------------------------------------------------------------------------
module bdlr_geom #(
    parameter int MAX_COLUMNS = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bdlr_stream_if.sink          cfg,
    input  logic [$clog2(((MAX_COLUMNS < 511) ? MAX_COLUMNS : 511) + 1) + bdlr_pkg::ROWS_W - 1:0]
                                 pos,
    output logic [$clog2(((MAX_COLUMNS < 511) ? MAX_COLUMNS : 511) + 1) - 1:0] cols,
    output logic [bdlr_pkg::ROWS_W-1:0] rows,
    output logic [$clog2(((MAX_COLUMNS < 511) ? MAX_COLUMNS : 511) + 1) + bdlr_pkg::ROWS_W - 1:0]
                                 total,
    output logic [$clog2(((MAX_COLUMNS < 511) ? MAX_COLUMNS : 511) + 1) + bdlr_pkg::ROWS_W - 1:0]
                                 period_m1,
    output logic                 busy,
    output logic                 div_done,
    output logic [$clog2(((MAX_COLUMNS < 511) ? MAX_COLUMNS : 511) + 1) - 1:0] div_col,
    output logic [bdlr_pkg::ROW_CNT_W-1:0] div_row
);

    localparam int CMAX  = (MAX_COLUMNS < 511) ? MAX_COLUMNS : 511;
    localparam int CW    = $clog2(CMAX + 1);
    localparam int P_W   = CW + bdlr_pkg::ROWS_W;
    localparam int CNT_W = $clog2(P_W + 1);

    typedef enum logic [3:0] {
        S_MUL  = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_IDLE = 4'b1000
    } geom_state_t;

    geom_state_t                       state_reg, state_next;
    logic [bdlr_pkg::COLS_REG_W-1:0]   cols_reg, cols_next;
    logic [bdlr_pkg::ROWS_W-1:0]       rows_reg, rows_next;
    logic                              done_reg, done_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;

    logic [CW-1:0]                     cols_eff_reg;
    logic [bdlr_pkg::ROWS_W-1:0]       rows_eff_reg;
    logic [P_W-1:0]                    total_reg;
    logic [P_W-1:0]                    period_m1_reg;
    logic [CW-1:0]                     rem_reg, rem_next;
    logic [P_W-1:0]                    quo_reg, quo_next;

    logic [CW-1:0]                     clamp_cols;
    logic [bdlr_pkg::ROWS_W-1:0]       clamp_rows;
    logic [CW:0]                       shifted;
    logic                              wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;

    always_comb
    begin
        if (cols_reg == '0)
        begin
            clamp_cols = CW'(1);
        end
        else if (cols_reg > bdlr_pkg::COLS_REG_W'(CMAX))
        begin
            clamp_cols = CW'(CMAX);
        end
        else
        begin
            clamp_cols = CW'(cols_reg);
        end
        clamp_rows = (rows_reg == '0) ? bdlr_pkg::ROWS_W'(1) : rows_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cols_next  = cols_reg;
        rows_next  = rows_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        shifted    = {rem_reg, quo_reg[P_W-1]};
        unique case (state_reg)
            S_MUL:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_DIV;
                cnt_next   = CNT_W'(P_W);
                rem_next   = '0;
                quo_next   = pos;
            end
            S_DIV:
            begin
                if (shifted >= {1'b0, cols_eff_reg})
                begin
                    rem_next = CW'(shifted - {1'b0, cols_eff_reg});
                    quo_next = {quo_reg[P_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[CW-1:0];
                    quo_next = {quo_reg[P_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_IDLE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_MUL;
            end
        endcase
        if (wr)
        begin
            state_next = S_MUL;
            done_next  = 1'b0;
            if (cfg.data.index == bdlr_pkg::REG_GRID_COLUMNS)
            begin
                cols_next = cfg.data.value[bdlr_pkg::COLS_REG_W-1:0];
            end
            else if (cfg.data.index == bdlr_pkg::REG_GRID_ROWS)
            begin
                rows_next = cfg.data.value[bdlr_pkg::ROWS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_MUL;
            cols_reg  <= bdlr_pkg::COLS_RESET;
            rows_reg  <= bdlr_pkg::ROWS_RESET;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cols_reg  <= cols_next;
            rows_reg  <= rows_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (state_reg == S_MUL)
        begin
            cols_eff_reg <= clamp_cols;
            rows_eff_reg <= clamp_rows;
            total_reg    <= P_W'(clamp_cols) * P_W'(clamp_rows);
        end
        if (state_reg == S_SUM)
        begin
            period_m1_reg <= total_reg + P_W'(cols_eff_reg);
        end
    end

    assign cols      = cols_eff_reg;
    assign rows      = rows_eff_reg;
    assign total     = total_reg;
    assign period_m1 = period_m1_reg;
    assign busy      = (state_reg != S_IDLE) || done_reg;
    assign div_done  = done_reg;
    assign div_col   = rem_reg;
    assign div_row   = quo_reg[bdlr_pkg::ROW_CNT_W-1:0];

endmodule

// ===== rtl/bdlr_front.sv =====
// ----------------------------------------------------------------------------
// bdlr_front
// Accepts cells, tracks frame position, writes the code/support rings and
// reads the neighbors of the cell one row plus one back; queues its request.
// ----------------------------------------------------------------------------
module bdlr_front #(
    parameter int MAX_COLUMNS = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bdlr_stream_if.sink          cells,
    input  logic [$clog2(((MAX_COLUMNS < 511) ? MAX_COLUMNS : 511) + 1) - 1:0] cols,
    input  logic [bdlr_pkg::ROWS_W-1:0] rows,
    input  logic [$clog2(((MAX_COLUMNS < 511) ? MAX_COLUMNS : 511) + 1) + bdlr_pkg::ROWS_W - 1:0]
                                 total,
    input  logic [$clog2(((MAX_COLUMNS < 511) ? MAX_COLUMNS : 511) + 1) + bdlr_pkg::ROWS_W - 1:0]
                                 period_m1,
    input  logic                 busy,
    input  logic                 div_done,
    input  logic [$clog2(((MAX_COLUMNS < 511) ? MAX_COLUMNS : 511) + 1) - 1:0] div_col,
    input  logic [bdlr_pkg::ROW_CNT_W-1:0] div_row,
    output logic [$clog2(((MAX_COLUMNS < 511) ? MAX_COLUMNS : 511) + 1) + bdlr_pkg::ROWS_W - 1:0]
                                 pos,
    input  logic [bdlr_pkg::QCNT_W-1:0] q_free,
    output logic                 push_valid,
    output bdlr_pkg::qentry_t    push_data
);

    localparam int CMAX = (MAX_COLUMNS < 511) ? MAX_COLUMNS : 511;
    localparam int CW   = $clog2(CMAX + 1);
    localparam int P_W  = CW + bdlr_pkg::ROWS_W;
    localparam int RW   = bdlr_pkg::ROW_CNT_W;
    localparam int RING = 2 * CMAX + 2;
    localparam int AW   = $clog2(RING);

    logic [P_W-1:0]                p_reg, p_next;
    logic [CW-1:0]                 pc_reg, pc_next;
    logic [RW-1:0]                 pr_reg, pr_next;
    logic [AW-1:0]                 wp_reg, wp_next;
    logic [bdlr_pkg::DIR_W-1:0]    last_sup_reg, last_sup_next;
    logic                          s1_valid_reg, s1_valid_next;
    logic [bdlr_pkg::DIR_W-1:0]    s1_flags_reg;
    logic                          s1_last_reg;

    logic                          acc;
    logic                          wrap;
    logic [P_W-1:0]                pe;
    logic [CW-1:0]                 pce, pce_inc;
    logic [RW-1:0]                 pre;
    logic [AW-1:0]                 wpe;
    logic                          pc0;
    logic [bdlr_pkg::CODE_W-1:0]   code_in;
    logic [bdlr_pkg::DIR_W-1:0]    sup_in;
    logic                          has_res;
    logic [bdlr_pkg::DIR_W-1:0]    flags;
    logic [AW:0]                   cols_w;
    logic [AW-1:0]                 addr_own, addr_up, addr_left, addr_right;
    logic [bdlr_pkg::CODE_W-1:0]   code_own, code_up;
    logic [bdlr_pkg::DIR_W-1:0]    sup_left, sup_right;
    logic [bdlr_pkg::DIR_W-1:0]    nbr_match;

    function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] wp,
                                                input logic [AW:0]   off);
        logic [AW:0] wide;
        wide = {1'b0, wp};
        if (wide >= off)
        begin
            return AW'(wide - off);
        end
        return AW'(wide + (AW+1)'(RING) - off);
    endfunction

    assign cells.ready = !busy && (q_free > bdlr_pkg::QCNT_W'(s1_valid_reg));
    assign acc         = cells.valid && cells.ready;
    assign pos         = p_reg;

    always_comb
    begin
        wrap    = p_reg > period_m1;
        pe      = wrap ? '0 : p_reg;
        pce     = wrap ? '0 : pc_reg;
        pre     = wrap ? '0 : pr_reg;
        wpe     = wrap ? '0 : wp_reg;
        pc0     = (pce == '0);
        pce_inc = pce + CW'(1);

        code_in = '0;
        if (pe < total && !cells.data.is_pad)
        begin
            code_in = cells.data.code_point;
        end
        sup_in = bdlr_pkg::support_of(code_in);

        has_res = (pre >= RW'(2)) || ((pre == RW'(1)) && !pc0);

        flags = '0;
        if (pc0 ? (pre >= RW'(3)) : (pre >= RW'(2)))
        begin
            flags = flags | bdlr_pkg::DIR_UP;
        end
        if ((pc0 ? (pre - RW'(1) < {1'b0, rows}) : (pre < {1'b0, rows}))
            && |(last_sup_reg & bdlr_pkg::DIR_UP))
        begin
            flags = flags | bdlr_pkg::DIR_DOWN;
        end
        if (pc0 ? (cols > CW'(1)) : (pce > CW'(1)))
        begin
            flags = flags | bdlr_pkg::DIR_LEFT;
        end
        if (!pc0)
        begin
            flags = flags | bdlr_pkg::DIR_RIGHT;
        end

        cols_w     = (AW+1)'(cols);
        addr_own   = ring_back(wpe, cols_w + (AW+1)'(1));
        addr_up    = ring_back(wpe, (AW+1)'({cols, 1'b1}));
        addr_left  = ring_back(wpe, cols_w + (AW+1)'(2));
        addr_right = ring_back(wpe, cols_w);
    end

    always_comb
    begin
        p_next        = p_reg;
        pc_next       = pc_reg;
        pr_next       = pr_reg;
        wp_next       = wp_reg;
        last_sup_next = last_sup_reg;
        s1_valid_next = 1'b0;
        if (div_done)
        begin
            pc_next = div_col;
            pr_next = div_row;
        end
        if (acc)
        begin
            s1_valid_next = has_res;
            last_sup_next = sup_in;
            if (pe == period_m1)
            begin
                p_next  = '0;
                pc_next = '0;
                pr_next = '0;
                wp_next = '0;
            end
            else
            begin
                p_next  = pe + P_W'(1);
                wp_next = (wpe == AW'(RING - 1)) ? '0 : wpe + AW'(1);
                if (pce_inc == cols)
                begin
                    pc_next = '0;
                    pr_next = pre + RW'(1);
                end
                else
                begin
                    pc_next = pce_inc;
                    pr_next = pre;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg        <= '0;
            pc_reg       <= '0;
            pr_reg       <= '0;
            wp_reg       <= '0;
            last_sup_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            p_reg        <= p_next;
            pc_reg       <= pc_next;
            pr_reg       <= pr_next;
            wp_reg       <= wp_next;
            last_sup_reg <= last_sup_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_flags_reg <= flags;
            s1_last_reg  <= (pe == period_m1);
        end
    end

    bdlr_ram #(
        .WIDTH (bdlr_pkg::CODE_W),
        .DEPTH (RING)
    ) u_code_ring (
        .clk     (clk),
        .we      (acc),
        .waddr   (wpe),
        .wdata   (code_in),
        .raddr_a (addr_own),
        .raddr_b (addr_up),
        .rdata_a (code_own),
        .rdata_b (code_up)
    );

    bdlr_ram #(
        .WIDTH (bdlr_pkg::DIR_W),
        .DEPTH (RING)
    ) u_sup_ring (
        .clk     (clk),
        .we      (acc),
        .waddr   (wpe),
        .wdata   (sup_in),
        .raddr_a (addr_left),
        .raddr_b (addr_right),
        .rdata_a (sup_left),
        .rdata_b (sup_right)
    );

    // down match already folded into the flags at accept time
    always_comb
    begin
        nbr_match = bdlr_pkg::DIR_DOWN;
        if (|(bdlr_pkg::support_of(code_up) & bdlr_pkg::DIR_DOWN))
        begin
            nbr_match = nbr_match | bdlr_pkg::DIR_UP;
        end
        if (|(sup_left & bdlr_pkg::DIR_RIGHT))
        begin
            nbr_match = nbr_match | bdlr_pkg::DIR_LEFT;
        end
        if (|(sup_right & bdlr_pkg::DIR_LEFT))
        begin
            nbr_match = nbr_match | bdlr_pkg::DIR_RIGHT;
        end
    end

    assign push_valid     = s1_valid_reg;
    assign push_data.code = code_own;
    assign push_data.nb   = s1_flags_reg & nbr_match;
    assign push_data.last = s1_last_reg;

endmodule

// ===== rtl/bdlr_queue.sv =====
// ----------------------------------------------------------------------------
// bdlr_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module bdlr_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push_valid,
    input  bdlr_pkg::qentry_t           push_data,
    output logic                        pop_valid,
    input  logic                        pop_ready,
    output bdlr_pkg::qentry_t           pop_data,
    output logic [bdlr_pkg::QCNT_W-1:0] free
);

    bdlr_pkg::qentry_t                 mem_reg [bdlr_pkg::QUEUE_DEPTH];
    logic [bdlr_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [bdlr_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [bdlr_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                              pop;

    function automatic logic [bdlr_pkg::QPTR_W-1:0] ptr_inc(
        input logic [bdlr_pkg::QPTR_W-1:0] p);
        if (p == bdlr_pkg::QPTR_W'(bdlr_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + bdlr_pkg::QPTR_W'(1);
    endfunction

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign free      = bdlr_pkg::QCNT_W'(bdlr_pkg::QUEUE_DEPTH) - count_reg;

    always_comb
    begin
        wr_ptr_next = push_valid ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + bdlr_pkg::QCNT_W'(push_valid)
                      - bdlr_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/bdlr_back.sv =====
// ----------------------------------------------------------------------------
// bdlr_back
// Resolves link mask to a box-drawing glyph; drives the output register.
// ----------------------------------------------------------------------------
module bdlr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  bdlr_pkg::qentry_t pop_data,
    bdlr_stream_if.source     glyphs
);

    logic                       out_valid_reg, out_valid_next;
    bdlr_pkg::glyph_t           out_data_reg;
    logic                       pop;
    logic [bdlr_pkg::DIR_W-1:0] links;

    assign pop_ready = !out_valid_reg || glyphs.ready;
    assign pop       = pop_valid && pop_ready;
    assign links     = bdlr_pkg::support_of(pop_data.code) & pop_data.nb;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (glyphs.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg.out_code_point <= bdlr_pkg::glyph_of(links, pop_data.code);
            out_data_reg.frame_last     <= pop_data.last;
        end
    end

    assign glyphs.valid = out_valid_reg;
    assign glyphs.data  = out_data_reg;

endmodule

// ===== rtl/box_drawing_ligature_raster_top.sv =====
// ----------------------------------------------------------------------------
// box_drawing_ligature_raster_top
// Box-drawing ligature rasterizer: raster-order cells in, joined glyphs out,
// one row plus one cell behind.
//
//   channel  dir  payload                          request when
//   cells    in   code_point[20:0], is_pad         valid && ready
//   glyphs   out  out_code_point[20:0], frame_last  valid && ready
//   cfg      in   index[3:0], value[11:0]          valid && ready (always ready)
//
// One cell per clock sustained while geometry is idle and the queue has room;
// code and support rings are written once and read twice per cell on
// one-write, two-read RAMs. A cell's glyph passes the ring read registers,
// the queue and the output register. After reset and after every cfg write,
// cells stalls while geometry and the bit-serial divider settle.
// Output stalls back up through a 4-entry queue before cells deasserts ready.
// ----------------------------------------------------------------------------
module box_drawing_ligature_raster_top #(
    parameter int MAX_COLUMNS = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    bdlr_stream_if.sink   cells,
    bdlr_stream_if.source glyphs,
    bdlr_stream_if.sink   cfg
);

    localparam int CMAX = (MAX_COLUMNS < 511) ? MAX_COLUMNS : 511;
    localparam int CW   = $clog2(CMAX + 1);
    localparam int P_W  = CW + bdlr_pkg::ROWS_W;

    logic [CW-1:0]                     cols;
    logic [bdlr_pkg::ROWS_W-1:0]       rows;
    logic [P_W-1:0]                    total;
    logic [P_W-1:0]                    period_m1;
    logic [P_W-1:0]                    pos;
    logic                              busy;
    logic                              div_done;
    logic [CW-1:0]                     div_col;
    logic [bdlr_pkg::ROW_CNT_W-1:0]    div_row;
    logic [bdlr_pkg::QCNT_W-1:0]       q_free;
    logic                              push_valid;
    bdlr_pkg::qentry_t                 push_data;
    logic                              pop_valid;
    logic                              pop_ready;
    bdlr_pkg::qentry_t                 pop_data;

    bdlr_geom #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pos       (pos),
        .cols      (cols),
        .rows      (rows),
        .total     (total),
        .period_m1 (period_m1),
        .busy      (busy),
        .div_done  (div_done),
        .div_col   (div_col),
        .div_row   (div_row)
    );

    bdlr_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cells      (cells),
        .cols       (cols),
        .rows       (rows),
        .total      (total),
        .period_m1  (period_m1),
        .busy       (busy),
        .div_done   (div_done),
        .div_col    (div_col),
        .div_row    (div_row),
        .pos        (pos),
        .q_free     (q_free),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    bdlr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .free       (q_free)
    );

    bdlr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .glyphs    (glyphs)
    );

endmodule
